FILE: rtl/core/lcpf_pkg.sv
package lcpf_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int FORCE_WIDTH = 48;
  localparam int POS_FRAC = POSITION_WIDTH - 8;
  localparam int MANT_W = 32;
  localparam int EXP_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EPS_I = 3'd0,
    REG_EPS_J = 3'd1,
    REG_SIG_I = 3'd2,
    REG_SIG_J = 3'd3,
    REG_Q_I   = 3'd4,
    REG_Q_J   = 3'd5
  } cfg_reg_t;

  // Value is (-1)^neg * m * 2^e, with m zero or its top bit set.
  typedef struct packed {
    logic                    neg;
    logic [MANT_W-1:0]       m;
    logic signed [EXP_W-1:0] e;
  } num_t;

  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_ADD,
    FOP_NORM
  } fop_t;

  typedef enum logic [1:0] {
    IT_DIV,
    IT_SQRT,
    IT_ROOT
  } iter_op_t;

  localparam num_t NUM_SIX = '{neg: 1'b0, m: 32'hC000_0000, e: -16'sd29};
  localparam num_t NUM_K56 = '{neg: 1'b0, m: 32'hE000_0000, e: -16'sd26};

  localparam int FOP_LAT = 4;
  localparam int ITER_STEPS = 33;
  localparam int ITER_LAT = ITER_STEPS + 2;

  localparam int T_D = 1;
  localparam int T_DN = T_D + FOP_LAT;
  localparam int T_SQ = T_DN + FOP_LAT;
  localparam int T_SXY = T_SQ + FOP_LAT;
  localparam int T_R2 = T_SXY + FOP_LAT;
  localparam int T_S = T_R2 + ITER_LAT;
  localparam int T_R3 = T_S + FOP_LAT;
  localparam int T_S3 = T_R3 + FOP_LAT;
  localparam int T_S6 = T_S3 + FOP_LAT;
  localparam int T_SUM = T_S6 + FOP_LAT;
  localparam int T_M1 = T_SUM + FOP_LAT;
  localparam int T_LJ = T_M1 + FOP_LAT;
  localparam int T_C = T_R3 + ITER_LAT;
  localparam int T_FAC = T_C + FOP_LAT;
  localparam int T_F = T_FAC + FOP_LAT;
  localparam int T_OUT = T_F + 2;

  function automatic logic [6:0] lzc64(input logic [63:0] x);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/lj_coulomb_pair_force_unit.sv
// Channel  Dir  Handshake             Beat contents
// cfg      in   cfg_write             cfg_index, cfg_data
// in       in   in_valid / in_ready   pos_ix, pos_iy, pos_iz, pos_jx, pos_jy, pos_jz
// out      out  out_valid / out_ready force_x, force_y, force_z, fault
//
// One beat is accepted per cycle while no finished result is waiting to be taken.
// The depth of the pipeline is set by the chained 35-stage square-root and divide units
// and the 4-stage float units.
// Reset clears the pipeline valid bits and the type registers.
// The whole pipeline holds while a finished result is not taken.
// Values derived from the type registers settle after a write, free of the stall.
module lj_coulomb_pair_force_unit (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_write,
  input  logic [lcpf_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [lcpf_pkg::CFG_DATA_W-1:0]              cfg_data,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic signed [lcpf_pkg::POSITION_WIDTH-1:0]   pos_ix,
  input  logic signed [lcpf_pkg::POSITION_WIDTH-1:0]   pos_iy,
  input  logic signed [lcpf_pkg::POSITION_WIDTH-1:0]   pos_iz,
  input  logic signed [lcpf_pkg::POSITION_WIDTH-1:0]   pos_jx,
  input  logic signed [lcpf_pkg::POSITION_WIDTH-1:0]   pos_jy,
  input  logic signed [lcpf_pkg::POSITION_WIDTH-1:0]   pos_jz,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic signed [lcpf_pkg::FORCE_WIDTH-1:0]      force_x,
  output logic signed [lcpf_pkg::FORCE_WIDTH-1:0]      force_y,
  output logic signed [lcpf_pkg::FORCE_WIDTH-1:0]      force_z,
  output logic                                         fault
);

  localparam int PW = lcpf_pkg::POSITION_WIDTH;
  localparam int FW = lcpf_pkg::FORCE_WIDTH;
  localparam int EW = lcpf_pkg::EXP_W;
  localparam int LAT = lcpf_pkg::FOP_LAT;
  localparam int ILAT = lcpf_pkg::ITER_LAT;
  localparam int TOUT = lcpf_pkg::T_OUT;
  localparam int SLJ_LEN = lcpf_pkg::T_M1 - lcpf_pkg::T_S;
  localparam int LJ_LEN = lcpf_pkg::T_C - lcpf_pkg::T_LJ;
  localparam int DN_LEN = lcpf_pkg::T_FAC - lcpf_pkg::T_DN;
  localparam int ZF_LEN = lcpf_pkg::T_F - lcpf_pkg::T_D;

  logic [31:0] eps_i, eps_j, sig_i, sig_j, q_i, q_j;

  logic en;
  logic vld [0:TOUT];

  logic signed [PW-1:0] pi [0:2];
  logic signed [PW-1:0] pj [0:2];
  logic signed [PW:0]   d  [0:2];
  logic [PW:0]          dabs [0:2];
  logic                 dzero;

  lcpf_pkg::num_t dn [0:2];
  lcpf_pkg::num_t sq [0:2];
  lcpf_pkg::num_t fk [0:2];
  lcpf_pkg::num_t dn_d [0:2][0:DN_LEN-1];
  lcpf_pkg::num_t sqz_d [0:LAT-1];
  lcpf_pkg::num_t r2_d [0:ILAT-1];
  lcpf_pkg::num_t s_d4 [0:LAT-1];
  lcpf_pkg::num_t s3_d [0:LAT-1];
  lcpf_pkg::num_t s_dlj [0:SLJ_LEN-1];
  lcpf_pkg::num_t lj_d [0:LJ_LEN-1];
  logic           zf [0:ZF_LEN-1];

  lcpf_pkg::num_t sxy, r2, s, sr, r3, s2, s3, s6, s6_adj, s3_neg, lj_sum, m1, lj, cq, fac;
  lcpf_pkg::num_t ep, sixep, sg, sg2, qn, cq56;
  logic [63:0]    epsp, qprod;
  logic [32:0]    ep_root;
  logic [32:0]    sg_sum;
  logic [31:0]    qa_abs, qb_abs;
  logic           qneg;

  logic [63:0] mag_a [0:2];
  logic        neg_a [0:2];
  logic        zf_a;
  logic [63:0] lim_b [0:2];
  logic [63:0] sel_b [0:2];
  logic [63:0] sgn_b [0:2];
  logic        sat_b [0:2];
  logic signed [EW-1:0] kk [0:2];
  logic [63:0] mag_n [0:2];
  logic [FW-1:0] fo [0:2];

  assign en = !vld[TOUT] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[TOUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      eps_i <= '0;
      eps_j <= '0;
      sig_i <= '0;
      sig_j <= '0;
      q_i <= '0;
      q_j <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lcpf_pkg::REG_EPS_I: eps_i <= cfg_data;
        lcpf_pkg::REG_EPS_J: eps_j <= cfg_data;
        lcpf_pkg::REG_SIG_I: sig_i <= cfg_data;
        lcpf_pkg::REG_SIG_J: sig_j <= cfg_data;
        lcpf_pkg::REG_Q_I:   q_i <= cfg_data;
        lcpf_pkg::REG_Q_J:   q_j <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= TOUT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i <= TOUT; i++) vld[i] <= vld[i-1];
    end
  end

  // Values that follow from the type registers alone run free of the stall.
  assign sg_sum = {1'b0, sig_i} + {1'b0, sig_j};
  assign qa_abs = q_i[31] ? (32'd0 - q_i) : q_i;
  assign qb_abs = q_j[31] ? (32'd0 - q_j) : q_j;

  always_ff @(posedge clk) begin
    epsp <= {32'b0, eps_i} * {32'b0, eps_j};
    qprod <= {32'b0, qa_abs} * {32'b0, qb_abs};
    qneg <= q_i[31] ^ q_j[31];
  end

  lcpf_iter u_ep_root (.clk, .en(1'b1), .op(lcpf_pkg::IT_ROOT), .a('0), .b('0), .x(epsp),
    .r(), .root(ep_root));
  lcpf_fop u_ep (.clk, .en(1'b1), .op(lcpf_pkg::FOP_NORM), .a('0), .b('0),
    .x({31'b0, ep_root}), .xe(-EW'(28)), .xneg(1'b0), .r(ep));
  lcpf_fop u_sixep (.clk, .en(1'b1), .op(lcpf_pkg::FOP_MUL), .a(lcpf_pkg::NUM_SIX), .b(ep),
    .x('0), .xe('0), .xneg(1'b0), .r(sixep));
  lcpf_fop u_sg (.clk, .en(1'b1), .op(lcpf_pkg::FOP_NORM), .a('0), .b('0),
    .x({31'b0, sg_sum}), .xe(-EW'(29)), .xneg(1'b0), .r(sg));
  lcpf_fop u_sg2 (.clk, .en(1'b1), .op(lcpf_pkg::FOP_MUL), .a(sg), .b(sg),
    .x('0), .xe('0), .xneg(1'b0), .r(sg2));
  lcpf_fop u_qn (.clk, .en(1'b1), .op(lcpf_pkg::FOP_NORM), .a('0), .b('0),
    .x(qprod), .xe(-EW'(56)), .xneg(qneg), .r(qn));
  lcpf_fop u_cq56 (.clk, .en(1'b1), .op(lcpf_pkg::FOP_MUL), .a(lcpf_pkg::NUM_K56), .b(qn),
    .x('0), .xe('0), .xneg(1'b0), .r(cq56));

  always_ff @(posedge clk) begin
    if (en) begin
      pi[0] <= pos_ix;
      pi[1] <= pos_iy;
      pi[2] <= pos_iz;
      pj[0] <= pos_jx;
      pj[1] <= pos_jy;
      pj[2] <= pos_jz;
      for (int k = 0; k < 3; k++) d[k] <= {pi[k][PW-1], pi[k]} - {pj[k][PW-1], pj[k]};
    end
  end

  assign dzero = (d[0] == '0) && (d[1] == '0) && (d[2] == '0);

  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign dabs[k] = d[k][PW] ? ((PW+1)'(0) - d[k]) : d[k];

    lcpf_fop u_dn (.clk, .en, .op(lcpf_pkg::FOP_NORM), .a('0), .b('0),
      .x({{(63-PW){1'b0}}, dabs[k]}), .xe(-EW'(lcpf_pkg::POS_FRAC)), .xneg(d[k][PW]),
      .r(dn[k]));
    lcpf_fop u_sq (.clk, .en, .op(lcpf_pkg::FOP_MUL), .a(dn[k]), .b(dn[k]),
      .x('0), .xe('0), .xneg(1'b0), .r(sq[k]));
    lcpf_fop u_f (.clk, .en, .op(lcpf_pkg::FOP_MUL), .a(fac), .b(dn_d[k][DN_LEN-1]),
      .x('0), .xe('0), .xneg(1'b0), .r(fk[k]));

    assign kk[k] = fk[k].e + EW'(16);

    always_comb begin
      if (fk[k].m == '0) begin
        mag_n[k] = '0;
      end else if (kk[k] < 0) begin
        if (kk[k] <= -EW'(32)) begin
          mag_n[k] = '0;
        end else begin
          mag_n[k] = {32'b0, fk[k].m} >> 5'(-kk[k]);
        end
      end else if (kk[k] > EW'(31)) begin
        mag_n[k] = '1;
      end else begin
        mag_n[k] = {32'b0, fk[k].m} << kk[k][4:0];
      end
      lim_b[k] = neg_a[k] ? (64'd1 << (FW-1)) : ((64'd1 << (FW-1)) - 64'd1);
      sat_b[k] = mag_a[k] > lim_b[k];
      sel_b[k] = sat_b[k] ? lim_b[k] : mag_a[k];
      sgn_b[k] = neg_a[k] ? (64'd0 - sel_b[k]) : sel_b[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dn_d[k][0] <= dn[k];
        for (int i = 1; i < DN_LEN; i++) dn_d[k][i] <= dn_d[k][i-1];
        mag_a[k] <= mag_n[k];
        neg_a[k] <= fk[k].neg;
        fo[k] <= sgn_b[k][FW-1:0];
      end
    end
  end

  lcpf_fop u_sxy (.clk, .en, .op(lcpf_pkg::FOP_ADD), .a(sq[0]), .b(sq[1]),
    .x('0), .xe('0), .xneg(1'b0), .r(sxy));
  lcpf_fop u_r2 (.clk, .en, .op(lcpf_pkg::FOP_ADD), .a(sxy), .b(sqz_d[LAT-1]),
    .x('0), .xe('0), .xneg(1'b0), .r(r2));
  lcpf_iter u_s (.clk, .en, .op(lcpf_pkg::IT_DIV), .a(sg2), .b(r2), .x('0),
    .r(s), .root());
  lcpf_iter u_sr (.clk, .en, .op(lcpf_pkg::IT_SQRT), .a(r2), .b('0), .x('0),
    .r(sr), .root());
  lcpf_fop u_r3 (.clk, .en, .op(lcpf_pkg::FOP_MUL), .a(r2_d[ILAT-1]), .b(sr),
    .x('0), .xe('0), .xneg(1'b0), .r(r3));
  lcpf_fop u_s2 (.clk, .en, .op(lcpf_pkg::FOP_MUL), .a(s), .b(s),
    .x('0), .xe('0), .xneg(1'b0), .r(s2));
  lcpf_fop u_s3 (.clk, .en, .op(lcpf_pkg::FOP_MUL), .a(s2), .b(s_d4[LAT-1]),
    .x('0), .xe('0), .xneg(1'b0), .r(s3));
  lcpf_fop u_s6 (.clk, .en, .op(lcpf_pkg::FOP_MUL), .a(s3), .b(s3),
    .x('0), .xe('0), .xneg(1'b0), .r(s6));

  always_comb begin
    s6_adj = s6;
    if (s6.m != '0) s6_adj.e = s6.e + EW'(1);
    s3_neg = s3_d[LAT-1];
    s3_neg.neg = (s3_d[LAT-1].m != '0);
  end

  lcpf_fop u_sum (.clk, .en, .op(lcpf_pkg::FOP_ADD), .a(s6_adj), .b(s3_neg),
    .x('0), .xe('0), .xneg(1'b0), .r(lj_sum));
  lcpf_fop u_m1 (.clk, .en, .op(lcpf_pkg::FOP_MUL), .a(sixep), .b(lj_sum),
    .x('0), .xe('0), .xneg(1'b0), .r(m1));
  lcpf_fop u_lj (.clk, .en, .op(lcpf_pkg::FOP_MUL), .a(m1), .b(s_dlj[SLJ_LEN-1]),
    .x('0), .xe('0), .xneg(1'b0), .r(lj));
  lcpf_iter u_cq (.clk, .en, .op(lcpf_pkg::IT_DIV), .a(cq56), .b(r3), .x('0),
    .r(cq), .root());
  lcpf_fop u_fac (.clk, .en, .op(lcpf_pkg::FOP_ADD), .a(lj_d[LJ_LEN-1]), .b(cq),
    .x('0), .xe('0), .xneg(1'b0), .r(fac));

  always_ff @(posedge clk) begin
    if (en) begin
      sqz_d[0] <= sq[2];
      s_d4[0] <= s;
      s3_d[0] <= s3;
      for (int i = 1; i < LAT; i++) begin
        sqz_d[i] <= sqz_d[i-1];
        s_d4[i] <= s_d4[i-1];
        s3_d[i] <= s3_d[i-1];
      end
      r2_d[0] <= r2;
      for (int i = 1; i < ILAT; i++) r2_d[i] <= r2_d[i-1];
      s_dlj[0] <= s;
      for (int i = 1; i < SLJ_LEN; i++) s_dlj[i] <= s_dlj[i-1];
      lj_d[0] <= lj;
      for (int i = 1; i < LJ_LEN; i++) lj_d[i] <= lj_d[i-1];
      zf[0] <= dzero;
      for (int i = 1; i < ZF_LEN; i++) zf[i] <= zf[i-1];
      zf_a <= zf[ZF_LEN-1];
      fault <= zf_a || sat_b[0] || sat_b[1] || sat_b[2];
    end
  end

  assign force_x = fo[0];
  assign force_y = fo[1];
  assign force_z = fo[2];

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while a result is stalled");

  a_zero_distance: assert property (@(posedge clk) disable iff (rst)
    (vld[TOUT-1] && zf_a && en) |=>
      (fault && force_x == '0 && force_y == '0 && force_z == '0))
    else $error("zero distance did not give a zero force with fault");
`endif

endmodule

FILE: rtl/core/lcpf_fop.sv
module lcpf_fop (
  input  logic                                clk,
  input  logic                                en,
  input  lcpf_pkg::fop_t                      op,
  input  lcpf_pkg::num_t                      a,
  input  lcpf_pkg::num_t                      b,
  input  logic [63:0]                         x,
  input  logic signed [lcpf_pkg::EXP_W-1:0]   xe,
  input  logic                                xneg,
  output lcpf_pkg::num_t                      r
);

  localparam int EW = lcpf_pkg::EXP_W;

  lcpf_pkg::num_t big;
  lcpf_pkg::num_t small_op;
  logic           swap;
  logic           small_zero;
  logic [EW:0]    diff;
  logic [63:0]    small_sh;
  logic [63:0]    y_al;
  logic [63:0]    prod;

  logic [63:0]          x1, y1, x2, x3;
  logic signed [EW-1:0] e1, e2, e3;
  logic                 neg1, neg2, neg3, sub1;
  logic [6:0]           lz3;
  logic [63:0]          xs4;
  logic signed [EW-1:0] lz_e;

  assign prod = {32'b0, a.m} * {32'b0, b.m};

  always_comb begin
    swap = ($signed(b.e) > $signed(a.e)) || ((b.e == a.e) && (b.m > a.m));
    big = swap ? b : a;
    small_op = swap ? a : b;
    small_zero = 1'b0;
    if (a.m == '0) begin
      big = b;
      small_zero = 1'b1;
    end else if (b.m == '0) begin
      big = a;
      small_zero = 1'b1;
    end
    diff = {big.e[EW-1], big.e} - {small_op.e[EW-1], small_op.e};
    small_sh = {1'b0, small_op.m, 31'b0};
    if (small_zero || (diff >= (EW+1)'(63))) begin
      y_al = '0;
    end else begin
      y_al = small_sh >> diff[5:0];
    end
  end

  assign lz_e = {{(EW-7){1'b0}}, lz3};
  assign xs4 = x3 << lz3;

  always_ff @(posedge clk) begin
    if (en) begin
      case (op)
        lcpf_pkg::FOP_MUL: begin
          x1 <= prod;
          y1 <= '0;
          e1 <= a.e + b.e;
          neg1 <= a.neg ^ b.neg;
          sub1 <= 1'b0;
        end
        lcpf_pkg::FOP_ADD: begin
          x1 <= {1'b0, big.m, 31'b0};
          y1 <= y_al;
          e1 <= big.e - EW'(31);
          neg1 <= big.neg;
          sub1 <= big.neg != small_op.neg;
        end
        default: begin
          x1 <= x;
          y1 <= '0;
          e1 <= xe;
          neg1 <= xneg;
          sub1 <= 1'b0;
        end
      endcase
      x2 <= sub1 ? (x1 - y1) : (x1 + y1);
      e2 <= e1;
      neg2 <= neg1;
      x3 <= x2;
      e3 <= e2;
      neg3 <= neg2;
      lz3 <= lcpf_pkg::lzc64(x2);
      if (x3 == '0) begin
        r <= '0;
      end else begin
        r.m <= xs4[63:32];
        r.e <= e3 + EW'(32) - lz_e;
        r.neg <= neg3;
      end
    end
  end

endmodule

FILE: rtl/core/lcpf_iter.sv
module lcpf_iter (
  input  logic                clk,
  input  logic                en,
  input  lcpf_pkg::iter_op_t  op,
  input  lcpf_pkg::num_t      a,
  input  lcpf_pkg::num_t      b,
  input  logic [63:0]         x,
  output lcpf_pkg::num_t      r,
  output logic [32:0]         root
);

  localparam int N = lcpf_pkg::ITER_STEPS;
  localparam int EW = lcpf_pkg::EXP_W;

  logic [35:0]          rem  [0:N];
  logic [65:0]          xs   [0:N];
  logic [32:0]          q    [0:N];
  logic [31:0]          den  [0:N];
  lcpf_pkg::iter_op_t   ops  [0:N];
  logic signed [EW-1:0] eb   [0:N];
  logic                 ng   [0:N];
  logic                 zr   [0:N];

  logic [35:0] cur     [0:N-1];
  logic [35:0] trial   [0:N-1];
  logic        ge      [0:N-1];
  logic [35:0] rem_n   [0:N-1];
  logic [65:0] xs_n    [0:N-1];
  logic [32:0] q_n     [0:N-1];

  logic [35:0]          rem0;
  logic [65:0]          xs0;
  logic signed [EW-1:0] eb0;
  logic signed [EW-1:0] sqe;
  logic                 ng0, zr0;
  logic [63:0]          sq_x;

  always_comb begin
    sqe = a.e[0] ? (a.e - EW'(31)) : (a.e - EW'(32));
    sq_x = a.e[0] ? {1'b0, a.m, 31'b0} : {a.m, 32'b0};
    case (op)
      lcpf_pkg::IT_DIV: begin
        rem0 = {5'b0, a.m[31:1]};
        xs0 = {a.m[0], 65'b0};
        eb0 = a.e - b.e - EW'(32);
        ng0 = a.neg ^ b.neg;
        zr0 = (a.m == '0) || (b.m == '0);
      end
      lcpf_pkg::IT_SQRT: begin
        rem0 = '0;
        xs0 = {2'b0, sq_x};
        eb0 = sqe >>> 1;
        ng0 = 1'b0;
        zr0 = (a.m == '0);
      end
      default: begin
        rem0 = '0;
        xs0 = {2'b0, x};
        eb0 = '0;
        ng0 = 1'b0;
        zr0 = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (ops[i] == lcpf_pkg::IT_DIV) begin
        cur[i] = {rem[i][34:0], xs[i][65]};
        xs_n[i] = {xs[i][64:0], 1'b0};
        trial[i] = {4'b0, den[i]};
      end else begin
        cur[i] = {rem[i][33:0], xs[i][65:64]};
        xs_n[i] = {xs[i][63:0], 2'b0};
        trial[i] = {1'b0, q[i], 2'b01};
      end
      ge[i] = cur[i] >= trial[i];
      rem_n[i] = ge[i] ? (cur[i] - trial[i]) : cur[i];
      q_n[i] = {q[i][31:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= rem0;
      xs[0] <= xs0;
      q[0] <= '0;
      den[0] <= b.m;
      ops[0] <= op;
      eb[0] <= eb0;
      ng[0] <= ng0;
      zr[0] <= zr0;
      for (int i = 1; i <= N; i++) begin
        rem[i] <= rem_n[i-1];
        xs[i] <= xs_n[i-1];
        q[i] <= q_n[i-1];
        den[i] <= den[i-1];
        ops[i] <= ops[i-1];
        eb[i] <= eb[i-1];
        ng[i] <= ng[i-1];
        zr[i] <= zr[i-1];
      end
      root <= q[N];
      if (zr[N]) begin
        r <= '0;
      end else begin
        r.m <= q[N][32] ? q[N][32:1] : q[N][31:0];
        r.e <= eb[N] + {{(EW-1){1'b0}}, q[N][32]};
        r.neg <= ng[N];
      end
    end
  end

endmodule

FILE: test/lj_coulomb_pair_force_unit_tb.sv
`timescale 1ns / 100ps

module lj_coulomb_pair_force_unit_tb;
  import lcpf_pkg::*;

  typedef struct {
    bit        neg;
    bit [31:0] m;
    int        e;
  } fnum_t;

  typedef struct {
    bit [31:0] ix, iy, iz, jx, jy, jz;
  } pair_t;

  typedef struct packed {
    bit [FORCE_WIDTH-1:0] fx, fy, fz;
    bit                   flt;
  } force_t;

  class force_scoreboard;
    bit [31:0] eps_i, eps_j, sig_i, sig_j, q_i, q_j;
    force_t    expected_q[$];
    int        mismatches;

    function void write_reg(cfg_reg_t idx, bit [31:0] v);
      case (idx)
        REG_EPS_I: eps_i = v;
        REG_EPS_J: eps_j = v;
        REG_SIG_I: sig_i = v;
        REG_SIG_J: sig_j = v;
        REG_Q_I:   q_i = v;
        REG_Q_J:   q_j = v;
        default: ;
      endcase
    endfunction

    function fnum_t fnorm(bit [63:0] x, int e, bit neg);
      fnum_t r;
      r.neg = 0;
      r.m = 0;
      r.e = 0;
      if (x == 0) return r;
      while (!x[63]) begin
        x = x << 1;
        e--;
      end
      r.m = x[63:32];
      r.e = e + 32;
      r.neg = neg;
      return r;
    endfunction

    function bit [63:0] isqrt(bit [63:0] x);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function fnum_t fmul(fnum_t a, fnum_t b);
      if (a.m == 0 || b.m == 0) return fnorm(0, 0, 0);
      return fnorm(64'(a.m) * 64'(b.m), a.e + b.e, a.neg != b.neg);
    endfunction

    function fnum_t fdiv(fnum_t a, fnum_t b);
      if (a.m == 0 || b.m == 0) return fnorm(0, 0, 0);
      return fnorm((64'(a.m) << 32) / 64'(b.m), a.e - b.e - 32, a.neg != b.neg);
    endfunction

    function fnum_t fsqrt(fnum_t a);
      if (a.m == 0) return a;
      if (a.e[0] == 0) return fnorm(isqrt(64'(a.m) << 32), (a.e - 32) / 2, 0);
      return fnorm(isqrt(64'(a.m) << 31), (a.e - 31) / 2, 0);
    endfunction

    function fnum_t fadd(fnum_t a, fnum_t b);
      fnum_t     t;
      bit [63:0] x, y;
      int        diff;
      if (a.m == 0) return b;
      if (b.m == 0) return a;
      if (b.e > a.e || (b.e == a.e && b.m > a.m)) begin
        t = a;
        a = b;
        b = t;
      end
      diff = a.e - b.e;
      x = 64'(a.m) << 31;
      y = (diff >= 63) ? 64'd0 : ((64'(b.m) << 31) >> diff);
      return fnorm((a.neg == b.neg) ? x + y : x - y, a.e - 31, a.neg);
    endfunction

    function bit [FORCE_WIDTH-1:0] to_force(fnum_t v, inout bit sat);
      int        k;
      bit [63:0] mag, lim;
      if (v.m == 0) return 0;
      k = v.e + 16;
      lim = (64'd1 << (FORCE_WIDTH - 1)) - (v.neg ? 64'd0 : 64'd1);
      if (k < 0) mag = (k <= -32) ? 64'd0 : (64'(v.m) >> (-k));
      else if (k > 31) mag = '1;
      else mag = 64'(v.m) << k;
      if (mag > lim) begin
        mag = lim;
        sat = 1;
      end
      return v.neg ? FORCE_WIDTH'(-mag) : FORCE_WIDTH'(mag);
    endfunction

    function force_t pair_force(pair_t p);
      fnum_t     dn[3], r2, sg, s, s3, s6, lj, cq, fac;
      bit [63:0] d, qa, qb;
      bit [31:0] pi_[3], pj_[3];
      bit        qneg, sat;
      force_t    f;
      pi_ = '{p.ix, p.iy, p.iz};
      pj_ = '{p.jx, p.jy, p.jz};
      sat = 0;
      for (int k = 0; k < 3; k++) begin
        d = 64'(signed'(pi_[k])) - 64'(signed'(pj_[k]));
        dn[k] = fnorm(d[63] ? -d : d, -POS_FRAC, d[63]);
      end
      r2 = fadd(fadd(fmul(dn[0], dn[0]), fmul(dn[1], dn[1])), fmul(dn[2], dn[2]));
      if (r2.m == 0) begin
        f = '{0, 0, 0, 1};
        return f;
      end
      sg = fnorm(64'(sig_i) + 64'(sig_j), -29, 0);
      s = fdiv(fmul(sg, sg), r2);
      s3 = fmul(fmul(s, s), s);
      s6 = fmul(s3, s3);
      if (s6.m != 0) s6.e++;
      s3.neg = (s3.m != 0);
      lj = fmul(fmul(fmul(fnorm(6, 0, 0), fnorm(isqrt(64'(eps_i) * 64'(eps_j)), -28, 0)),
                     fadd(s6, s3)), s);
      qa = 64'(signed'(q_i));
      qb = 64'(signed'(q_j));
      qneg = qa[63] ^ qb[63];
      if (qa[63]) qa = -qa;
      if (qb[63]) qb = -qb;
      cq = fdiv(fmul(fnorm(56, 0, 0), fnorm(qa * qb, -56, qneg)), fmul(r2, fsqrt(r2)));
      fac = fadd(lj, cq);
      f.fx = to_force(fmul(fac, dn[0]), sat);
      f.fy = to_force(fmul(fac, dn[1]), sat);
      f.fz = to_force(fmul(fac, dn[2]), sat);
      f.flt = sat;
      return f;
    endfunction

    function void note_pair(pair_t p);
      expected_q.push_back(pair_force(p));
    endfunction

    function void check_force(force_t got);
      force_t exp_f;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h %h %h %b",
                                       got.fx, got.fy, got.fz, got.flt);
        return;
      end
      exp_f = expected_q.pop_front();
      if (exp_f != got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("force mismatch: expected %h %h %h %b, got %h %h %h %b",
                   exp_f.fx, exp_f.fy, exp_f.fz, exp_f.flt, got.fx, got.fy, got.fz, got.flt);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready, fault;
  logic signed [POSITION_WIDTH-1:0] pos_ix, pos_iy, pos_iz, pos_jx, pos_jy, pos_jz;
  logic signed [FORCE_WIDTH-1:0] force_x, force_y, force_z;

  force_scoreboard sb;
  bit tx_calm, rx_calm;

  lj_coulomb_pair_force_unit DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_pair('{pos_ix, pos_iy, pos_iz, pos_jx, pos_jy, pos_jz});
    if (!rst && out_valid && out_ready)
      sb.check_force('{force_x, force_y, force_z, fault});
  end

  always @(posedge clk) begin
    out_ready <= rx_calm ? 1'b1 : ($urandom_range(99) >= 25);
  end

  task automatic write_reg(cfg_reg_t idx, bit [31:0] v);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  task automatic load_types(bit [31:0] ei, ej, si, sj, qi, qj);
    drain();
    write_reg(REG_EPS_I, ei);
    write_reg(REG_EPS_J, ej);
    write_reg(REG_SIG_I, si);
    write_reg(REG_SIG_J, sj);
    write_reg(REG_Q_I, qi);
    write_reg(REG_Q_J, qj);
    cfg_write <= 0;
    repeat (60) @(posedge clk);
  endtask

  task automatic send_pair(pair_t p);
    while (!tx_calm && $urandom_range(99) < 25) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    pos_ix <= p.ix;
    pos_iy <= p.iy;
    pos_iz <= p.iz;
    pos_jx <= p.jx;
    pos_jy <= p.jy;
    pos_jz <= p.jz;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic pair_t random_pair();
    pair_t     p;
    bit [31:0] off[3];
    int        mode;
    mode = $urandom_range(9);
    p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (mode >= 2) begin
      for (int k = 0; k < 3; k++)
        off[k] = (mode == 9 && $urandom_range(1)) ? 32'd0 :
                 32'(signed'($urandom) >>> $urandom_range(4, 22));
      p.jx = p.ix - off[0];
      p.jy = p.iy - off[1];
      p.jz = p.iz - off[2];
    end
    return p;
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_pair(random_pair());
  endtask

  task automatic send_directed();
    pair_t list[$];
    list = '{
      '{0, 0, 0, 0, 0, 0},
      '{32'h7FFF_FFFF, 32'h1234_5678, 0, 32'h7FFF_FFFF, 32'h1234_5678, 0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0},
      '{1, 0, 0, 0, 0, 0},
      '{0, 0, 1, 0, 0, 0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0},
      '{32'h0100_0000, 0, 0, 0, 0, 0},
      '{0, 32'h0050_0000, 0, 0, 0, 0},
      '{32'h0040_0000, 32'h0040_0000, 32'h0040_0000, 0, 0, 0},
      '{32'h0200_0000, 32'hFE00_0000, 32'h0100_0000, 32'hFFFF_0000, 0, 32'h0001_0000},
      '{32'h0000_1000, 0, 0, 0, 0, 0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}
    };
    foreach (list[i]) send_pair(list[i]);
  endtask

  initial begin
    sb = new();
    rst = 1;
    cfg_write = 0;
    cfg_index = REG_EPS_I;
    cfg_data = 0;
    in_valid = 0;
    {pos_ix, pos_iy, pos_iz, pos_jx, pos_jy, pos_jz} = '0;
    tx_calm = 0;
    rx_calm = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_random(20);
    load_types(32'h0800_0000, 32'h0A00_0000, 32'h04CC_CCCD, 32'h0555_5555,
               32'h0800_0000, 32'hF800_0000);
    send_directed();
    send_random(100);
    drain();
    send_random(60);
    load_types('1, '1, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_directed();
    send_random(100);
    load_types(32'h0100_0000, 32'h0040_0000, 32'h0200_0000, 32'h0300_0000,
               32'h8000_0000, 32'h8000_0000);
    tx_calm = 1;
    rx_calm = 1;
    send_random(120);
    tx_calm = 0;
    rx_calm = 0;
    load_types($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_random(100);
    load_types(0, 32'h1000_0000, 32'h0400_0000, 0, 32'h0266_6666, 0);
    send_random(50);
    load_types($urandom, $urandom, $urandom_range(32'h0800_0000), $urandom_range(32'h0800_0000),
               $urandom, $urandom);
    send_random(100);
    in_valid <= 0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
